FILE: src/neighbour_median_denoise_assert.svh
// Assertion macros for the neighbour median denoiser checker.
`ifndef NEIGHBOUR_MEDIAN_DENOISE_ASSERT_SVH
`define NEIGHBOUR_MEDIAN_DENOISE_ASSERT_SVH

// General property on the output port, clocked and reset-qualified.
`define NMD_ASSERT_OUT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// A stalled result keeps the given output signal unchanged.
`define NMD_ASSERT_HOLD(label, sig, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (out_valid_o && !out_ready_i) |=> $stable(sig)) else $error(msg);

`endif

FILE: src/nmd_pkg.sv
// Shared types and constants of the neighbour median denoiser.
`timescale 1ns / 1ps
`default_nettype none

package nmd_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned COORD_W    = 10;
  localparam int unsigned CFG_W      = 11;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned NEIGHBOURS = 8;
  localparam int unsigned WIN_TAPS   = 9;
  localparam int unsigned MIN_DIM    = 3;
  localparam int unsigned MAX_DIM    = 1 << COORD_W;
  localparam int unsigned RST_WIDTH  = 640;
  localparam int unsigned RST_HEIGHT = 480;
  localparam int unsigned QDEPTH     = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  // Result slots of one input pixel, in emission order
  localparam logic [2:0] RES_CENTER   = 3'b001;
  localparam logic [2:0] RES_ROW_END  = 3'b010;
  localparam logic [2:0] RES_LAST_ROW = 3'b100;

  typedef logic [NEIGHBOURS-1:0][PIX_W-1:0] nbhd_t;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] wm1;
    logic [PIX_W-1:0]   pix;
    logic               last_col;
    logic               last_row;
  } item_t;

  typedef struct packed {
    item_t            it;
    logic [PIX_W-1:0] center;
    logic [PIX_W-1:0] above;
  } ctx_t;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] wm1;
    logic [PIX_W-1:0]   p0;
    logic               rep0;
    logic [PIX_W-1:0]   p1;
    logic [PIX_W-1:0]   p2;
    logic [2:0]         mask;
    logic               last_col;
  } entry_t;

endpackage

`default_nettype wire

FILE: src/nmd_median.sv
// Two-stage sorting network: mean of the 4th and 5th smallest of eight neighbours.
`timescale 1ns / 1ps
`default_nettype none

module nmd_median import nmd_pkg::*; (
  input  logic             clk_i,
  input  nbhd_t            nb_i,
  output logic [PIX_W-1:0] med_o
);

  nbhd_t            part_d, part_q;
  logic [PIX_W-1:0] med_d, med_q;

  // returns {high, low}
  function automatic logic [2*PIX_W-1:0] cas(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
    return (a > b) ? {a, b} : {b, a};
  endfunction

  // odd-even merge sort, layers 1 to 3
  always_comb begin
    nbhd_t x;
    x = nb_i;
    {x[1], x[0]} = cas(x[0], x[1]);
    {x[3], x[2]} = cas(x[2], x[3]);
    {x[5], x[4]} = cas(x[4], x[5]);
    {x[7], x[6]} = cas(x[6], x[7]);
    {x[2], x[0]} = cas(x[0], x[2]);
    {x[3], x[1]} = cas(x[1], x[3]);
    {x[6], x[4]} = cas(x[4], x[6]);
    {x[7], x[5]} = cas(x[5], x[7]);
    {x[2], x[1]} = cas(x[1], x[2]);
    {x[6], x[5]} = cas(x[5], x[6]);
    part_d = x;
  end

  // layers 4 and 5; the last layer only orders pairs 1/2, 3/4 and 5/6, which the sum does not need
  always_comb begin
    nbhd_t          y;
    logic [PIX_W:0] sum;
    y = part_q;
    {y[4], y[0]} = cas(y[0], y[4]);
    {y[5], y[1]} = cas(y[1], y[5]);
    {y[6], y[2]} = cas(y[2], y[6]);
    {y[7], y[3]} = cas(y[3], y[7]);
    {y[4], y[2]} = cas(y[2], y[4]);
    {y[5], y[3]} = cas(y[3], y[5]);
    sum   = {1'b0, y[3]} + {1'b0, y[4]};
    med_d = sum[PIX_W:1];
  end

  always_ff @(posedge clk_i) begin
    part_q <= part_d;
    med_q  <= med_d;
  end

  assign med_o = med_q;

endmodule

`default_nettype wire

FILE: src/neighbour_median_denoise.sv
// neighbour_median_denoise: 3x3 neighbour-median filter over a raster 8-bit pixel stream.
// Config: cfg_index_i 0 = frame_width, 1 = frame_height, clamped to 3..1024 (width also
//   to MAX_WIDTH); cfg_ready_o is always high; write only while the block is drained.
// Input: one pixel per request on in_valid_i / in_ready_o, in raster order.
// Output: one result per request: row, column, pixel, replaced flag, frame-done mark.
//   Pixel (r,c) is reported when the input at (r+1,c+1) arrives, at a row end, or
//   directly when it lies in the last row.
// Path: an input passes stages s1 to s4 and the result queue before its first result;
//   further results of the same input follow one per cycle while out_ready_i is high.
// Throughput: one pixel per cycle while in_ready_o is high. The output sends one result per
//   cycle while out_ready_i is high, and a row end or a last-row input can yield more than one.
// Line stores: two MAX_WIDTH x 8 memories, read at the accepting edge and written back
//   in the cycle after from stage s1; consecutive pixels address different columns.
// Reset: geometry 640 x 480, position row 0 column 0, window cleared, queue empty. The
//   line stores are not cleared; row 0 fills them before any read value is used.
// Stall: an 8-entry result queue sits before the output; in_ready_o drops when queued
//   plus in-flight entries would fill it, so out_ready_i may stay low for any time.
`timescale 1ns / 1ps
`default_nettype none

module neighbour_median_denoise import nmd_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [PIX_W-1:0]     pixel_in_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [COORD_W-1:0]   out_row_o,
  output logic [COORD_W-1:0]   out_col_o,
  output logic [PIX_W-1:0]     out_pixel_o,
  output logic                 was_replaced_o,
  output logic                 frame_done_o
);

  localparam int unsigned AW      = $clog2(MAX_WIDTH);
  localparam int unsigned WCAP    = (MAX_WIDTH < MAX_DIM) ? MAX_WIDTH : MAX_DIM;
  localparam int unsigned RST_W   = (RST_WIDTH < WCAP) ? RST_WIDTH : WCAP;
  localparam int unsigned QAW     = $clog2(QDEPTH);
  localparam int unsigned OCC_W   = QAW + 2;

  function automatic logic [COORD_W-1:0] clamp_m1(logic [CFG_W-1:0] v, logic [CFG_W-1:0] cap);
    logic [CFG_W-1:0] t;
    t = v;
    if (v < CFG_W'(MIN_DIM)) t = CFG_W'(MIN_DIM);
    else if (v > cap)        t = cap;
    return COORD_W'(t - CFG_W'(1));
  endfunction

  // geometry, kept as last column / last row index
  logic [COORD_W-1:0] wm1_q, hm1_q;
  logic [COORD_W-1:0] col_q, col_d, row_q, row_d;
  logic               in_acc, out_acc;
  logic               last_col, last_row;

  // line stores
  logic [PIX_W-1:0] mem_a [MAX_WIDTH];
  logic [PIX_W-1:0] mem_b [MAX_WIDTH];
  logic [PIX_W-1:0] rda_q, rdb_q;
  logic [AW-1:0]    rd_addr, wr_addr;

  // pipeline
  item_t                            s1_q, s2_q;
  ctx_t                             s3_q, s4_q;
  logic                             s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q;
  logic [WIN_TAPS-1:0][PIX_W-1:0]   win_q;
  nbhd_t                            nb;
  logic [PIX_W-1:0]                 med;

  // result queue
  entry_t             q_mem [QDEPTH];
  entry_t             entry_d, head;
  logic               push, pop;
  logic [QAW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [QAW:0]       count_q, count_d;
  logic [OCC_W-1:0]   occ;
  logic [2:0]         sent_q, sent_d, rem, sel;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wm1_q <= COORD_W'(RST_W - 1);
      hm1_q <= COORD_W'(RST_HEIGHT - 1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_FRAME_WIDTH:  wm1_q <= clamp_m1(cfg_data_i, CFG_W'(WCAP));
        REG_FRAME_HEIGHT: hm1_q <= clamp_m1(cfg_data_i, CFG_W'(MAX_DIM));
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- raster position
  assign in_acc   = in_valid_i & in_ready_o;
  assign last_col = col_q >= wm1_q;
  assign last_row = row_q >= hm1_q;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_acc) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + COORD_W'(1);
      end else begin
        col_d = col_q + COORD_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------------------------------------------------------- line stores
  assign rd_addr = AW'(col_q);
  assign wr_addr = AW'(s1_q.col);

  // read at accept, write back from stage s1 in the cycle after; the next read of a
  // column is at least three pixels away, so read and write never meet on one entry
  always_ff @(posedge clk_i) begin
    if (in_acc) rda_q <= mem_a[rd_addr];
    if (s1_vld_q) mem_a[wr_addr] <= s1_q.pix;
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) rdb_q <= mem_b[rd_addr];
    if (s1_vld_q) mem_b[wr_addr] <= rda_q;
  end

  // ---------------------------------------------------------------- pipeline
  always_ff @(posedge clk_i) begin
    s1_q.row      <= row_q;
    s1_q.col      <= col_q;
    s1_q.wm1      <= wm1_q;
    s1_q.pix      <= pixel_in_i;
    s1_q.last_col <= last_col;
    s1_q.last_row <= last_row;
    s2_q          <= s1_q;
    s3_q.it       <= s2_q;
    s3_q.center   <= win_q[4];
    s3_q.above    <= win_q[5];
    s4_q          <= s3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= in_acc;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
    end
  end

  // window: columns shift left, newest column is {row r-2, row r-1, row r}
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (s1_vld_q) begin
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
      win_q[2] <= rdb_q;
      win_q[3] <= win_q[4];
      win_q[4] <= win_q[5];
      win_q[5] <= rda_q;
      win_q[6] <= win_q[7];
      win_q[7] <= win_q[8];
      win_q[8] <= s1_q.pix;
    end
  end

  assign nb = {win_q[8], win_q[7], win_q[6], win_q[5],
               win_q[3], win_q[2], win_q[1], win_q[0]};

  nmd_median u_median (
    .clk_i (clk_i),
    .nb_i  (nb),
    .med_o (med)
  );

  // ---------------------------------------------------------------- result bundle
  always_comb begin
    logic r_ge1, c_ge1, inner;
    r_ge1            = s4_q.it.row != '0;
    c_ge1            = s4_q.it.col != '0;
    inner            = (s4_q.it.row > COORD_W'(1)) && (s4_q.it.col > COORD_W'(1));
    entry_d.row      = s4_q.it.row;
    entry_d.col      = s4_q.it.col;
    entry_d.wm1      = s4_q.it.wm1;
    entry_d.p0       = inner ? med : s4_q.center;
    entry_d.rep0     = inner && (med != s4_q.center);
    entry_d.p1       = s4_q.above;
    entry_d.p2       = s4_q.it.pix;
    entry_d.mask     = {s4_q.it.last_row, r_ge1 & s4_q.it.last_col, r_ge1 & c_ge1};
    entry_d.last_col = s4_q.it.last_col;
  end

  assign push = s4_vld_q && (entry_d.mask != 3'b000);

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_ptr_q] <= entry_d;
  end

  // ---------------------------------------------------------------- output
  assign head        = q_mem[rd_ptr_q];
  assign out_valid_o = count_q != '0;
  assign out_acc     = out_valid_o & out_ready_i;
  assign rem         = head.mask & ~sent_q;
  assign sel         = rem & (~rem + 3'b001);
  assign pop         = out_acc && ((rem & ~sel) == 3'b000);

  always_comb begin
    out_row_o      = '0;
    out_col_o      = '0;
    out_pixel_o    = '0;
    was_replaced_o = 1'b0;
    frame_done_o   = 1'b0;
    case (sel)
      RES_CENTER: begin
        out_row_o      = head.row - COORD_W'(1);
        out_col_o      = head.col - COORD_W'(1);
        out_pixel_o    = head.p0;
        was_replaced_o = head.rep0;
      end
      RES_ROW_END: begin
        out_row_o   = head.row - COORD_W'(1);
        out_col_o   = head.wm1;
        out_pixel_o = head.p1;
      end
      RES_LAST_ROW: begin
        out_row_o    = head.row;
        out_col_o    = head.col;
        out_pixel_o  = head.p2;
        frame_done_o = head.last_col;
      end
      default: ;
    endcase
  end

  always_comb begin
    sent_d = sent_q;
    if (out_acc) sent_d = pop ? 3'b000 : (sent_q | sel);
    count_d = count_q + (QAW+1)'(push) - (QAW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
      sent_q   <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + QAW'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + QAW'(1);
      count_q <= count_d;
      sent_q  <= sent_d;
    end
  end

  // every in-flight pixel holds a reserved queue slot
  assign occ = OCC_W'(count_q) + OCC_W'(s1_vld_q) + OCC_W'(s2_vld_q)
             + OCC_W'(s3_vld_q) + OCC_W'(s4_vld_q);
  assign in_ready_o = occ < OCC_W'(QDEPTH);

endmodule

`default_nettype wire

FILE: src/nmd_checker.sv
// Port-level checker for the neighbour median denoiser, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "neighbour_median_denoise_assert.svh"

module nmd_checker import nmd_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic [COORD_W-1:0] out_row_o,
  input wire logic [COORD_W-1:0] out_col_o,
  input wire logic [PIX_W-1:0]   out_pixel_o,
  input wire logic               was_replaced_o,
  input wire logic               frame_done_o
);

  `NMD_ASSERT_HOLD(a_valid_hold, out_valid_o, "result request dropped while stalled")
  `NMD_ASSERT_HOLD(a_pixel_hold, out_pixel_o, "result pixel changed while stalled")
  `NMD_ASSERT_OUT(a_border_kept, (out_valid_o && was_replaced_o) |-> (out_row_o != 0 && out_col_o != 0), "border pixel flagged as replaced")
  `NMD_ASSERT_OUT(a_done_corner, (out_valid_o && frame_done_o) |-> (out_row_o >= 2 && out_col_o >= 2), "frame end outside the last corner")

endmodule

bind neighbour_median_denoise nmd_checker u_nmd_checker (.*);

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking bench for the 3x3 neighbour-median denoiser: raster frames in, pixel stream out.
`timescale 1ns / 1ps

module tb_top;
  import nmd_pkg::*;

  localparam int unsigned CLK_PERIOD    = 20;
  localparam int unsigned RST_CYCLES    = 9;
  localparam int unsigned MAX_WAIT      = 17;
  localparam int unsigned DRAIN_CYCLES  = 8;        // covers the path from an accepted pixel to its first result
  localparam int unsigned RANDOM_ITEMS  = 320;
  localparam int unsigned HOLD_AFTER    = 150;      // results seen before the long output stall
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned REPORT_CAP    = 100;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned CENTER_TAP    = 4;
  localparam int unsigned MIDFRAME_MAXW = 16;
  localparam int unsigned WIDE_LEAD     = 7;        // row 0 pixels sent at the widest setting
  localparam int unsigned TALL_LEAD     = 15;       // pixels sent at the tallest setting
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [PIX_W-1:0]   pixel;
    logic               replaced;
    logic               done;
  } denoise_result_t;

  // Tracks geometry, line stores and window; queues the pixels each request must release.
  class median_checker;
    logic [PIX_W-1:0] row_above  [MAX_DIM];
    logic [PIX_W-1:0] row_above2 [MAX_DIM];
    bit               above_known  [MAX_DIM];
    bit               above2_known [MAX_DIM];
    logic [PIX_W-1:0] win [WIN_TAPS];
    int unsigned      row_pos;
    int unsigned      col_pos;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    denoise_result_t  due_pixels [$];
    int unsigned      errors;

    function new();
      width_reg  = CFG_W'(RST_WIDTH);
      height_reg = CFG_W'(RST_HEIGHT);
      foreach (row_above[i]) begin
        row_above[i]    = '0;
        row_above2[i]   = '0;
        above_known[i]  = 1'b0;
        above2_known[i] = 1'b0;
      end
      foreach (win[i]) win[i] = '0;
      row_pos = 0;
      col_pos = 0;
      errors  = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == REG_FRAME_WIDTH) width_reg = data;
      else if (idx == REG_FRAME_HEIGHT) height_reg = data;
    endfunction

    function int unsigned clamp_dim(int unsigned v);
      if (v < MIN_DIM) return MIN_DIM;
      if (v > MAX_DIM) return MAX_DIM;
      return v;
    endfunction

    function int unsigned eff_width();
      return clamp_dim(width_reg);
    endfunction

    function int unsigned eff_height();
      return clamp_dim(height_reg);
    endfunction

    // Leading columns whose both line store entries hold real pixels.
    function int unsigned settled_width();
      int unsigned n;
      n = 0;
      while (n < MAX_DIM && above_known[n] && above2_known[n]) n++;
      return n;
    endfunction

    function bit at_frame_start();
      return row_pos == 0 && col_pos == 0;
    endfunction

    function int unsigned pending();
      return due_pixels.size();
    endfunction

    function logic [PIX_W-1:0] neighbour_median();
      logic [PIX_W-1:0] v [NEIGHBOURS];
      logic [PIX_W-1:0] t;
      int n, i, j;
      n = 0;
      for (i = 0; i < WIN_TAPS; i++) begin
        if (i != CENTER_TAP) begin
          v[n] = win[i];
          n++;
        end
      end
      for (i = 1; i < NEIGHBOURS; i++) begin
        t = v[i];
        j = i - 1;
        while (j >= 0 && v[j] > t) begin
          v[j + 1] = v[j];
          j--;
        end
        v[j + 1] = t;
      end
      return PIX_W'((int'(v[NEIGHBOURS/2 - 1]) + int'(v[NEIGHBOURS/2])) / 2);
    endfunction

    function void expect_pixel(int unsigned r, int unsigned c, logic [PIX_W-1:0] p,
                               logic rep, logic done);
      denoise_result_t e;
      e.row      = COORD_W'(r);
      e.col      = COORD_W'(c);
      e.pixel    = p;
      e.replaced = rep;
      e.done     = done;
      due_pixels.push_back(e);
    endfunction

    function void note_pixel(logic [PIX_W-1:0] p);
      int unsigned      w, h, r, c;
      bit               last_col, last_row;
      logic [PIX_W-1:0] above, above2, orig, med;
      w = eff_width();
      h = eff_height();
      r = row_pos;
      c = col_pos;
      // positions past the end after a geometry change count as the end
      last_col = c >= w - 1;
      last_row = r >= h - 1;
      above  = row_above[c];
      above2 = row_above2[c];
      row_above2[c]   = above;
      above2_known[c] = above_known[c];
      row_above[c]    = p;
      above_known[c]  = 1'b1;
      for (int k = 0; k < 3; k++) begin
        win[k*3]     = win[k*3 + 1];
        win[k*3 + 1] = win[k*3 + 2];
      end
      win[2] = above2;
      win[5] = above;
      win[8] = p;
      if (r >= 1) begin
        if (c >= 1) begin
          orig = win[CENTER_TAP];
          if (r >= 2 && c >= 2) begin
            med = neighbour_median();
            expect_pixel(r - 1, c - 1, med, med != orig, 1'b0);
          end else begin
            expect_pixel(r - 1, c - 1, orig, 1'b0, 1'b0);
          end
        end
        if (last_col) expect_pixel(r - 1, w - 1, win[5], 1'b0, 1'b0);
      end
      if (last_row) expect_pixel(r, c, p, 1'b0, last_col);
      if (last_col) begin
        col_pos = 0;
        row_pos = last_row ? 0 : (r + 1) % MAX_DIM;
      end else begin
        col_pos = (c + 1) % MAX_DIM;
      end
    endfunction

    function void report_field(string field, denoise_result_t want, int unsigned exp_v,
                               int unsigned act_v);
      errors++;
      if (errors <= REPORT_CAP)
        $display("%0t: %s of pixel (%0d,%0d): expected %0d, got %0d",
                 $time, field, want.row, want.col, exp_v, act_v);
    endfunction

    function void check_result(denoise_result_t got);
      denoise_result_t want;
      if (due_pixels.size() == 0) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t: unexpected pixel (%0d,%0d) value %0d: expected none, got one",
                   $time, got.row, got.col, got.pixel);
        return;
      end
      want = due_pixels.pop_front();
      if (got.row !== want.row) report_field("row", want, want.row, got.row);
      if (got.col !== want.col) report_field("col", want, want.col, got.col);
      if (got.pixel !== want.pixel) report_field("pixel", want, want.pixel, got.pixel);
      if (got.replaced !== want.replaced)
        report_field("replaced", want, want.replaced, got.replaced);
      if (got.done !== want.done) report_field("frame_done", want, want.done, got.done);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [PIX_W-1:0]     pixel_in = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [COORD_W-1:0]   out_row;
  logic [COORD_W-1:0]   out_col;
  logic [PIX_W-1:0]     out_pixel;
  logic                 was_replaced;
  logic                 frame_done;

  median_checker pixel_board = new();
  int unsigned   results_seen = 0;
  int unsigned   cycle_count = 0;
  int unsigned   send_burst = 0;
  int unsigned   recv_burst = 0;

  neighbour_median_denoise i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .pixel_in_i     (pixel_in),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .out_row_o      (out_row),
    .out_col_o      (out_col),
    .out_pixel_o    (out_pixel),
    .was_replaced_o (was_replaced),
    .frame_done_o   (frame_done)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Wait before a request: mostly random, with runs of back-to-back requests.
  function automatic int unsigned draw_wait(inout int unsigned burst_left);
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, MAX_WAIT);
  endfunction

  // Flat area around base with salt, pepper and random outliers.
  function automatic logic [PIX_W-1:0] make_pixel(logic [PIX_W-1:0] base);
    int v;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return PIX_W'($urandom_range(0, 255));
      default: begin
        v = int'(base) + int'($urandom_range(0, 6)) - 3;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return PIX_W'(v);
      end
    endcase
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] p);
    int unsigned gap;
    gap = draw_wait(send_burst);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_in <= p;
    do @(posedge clk); while (!in_ready);
    pixel_board.note_pixel(p);
  endtask

  task automatic finish_frame(input logic [PIX_W-1:0] base, output int unsigned sent);
    sent = 0;
    do begin
      send_pixel(make_pixel(base));
      sent++;
    end while (!pixel_board.at_frame_start());
  endtask

  // Rows may end with no result, so allow the pipeline to settle after the last one.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pixel_board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    pixel_board.set_reg(idx, data);
  endtask

  task automatic set_geometry(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_SPARE, CFG_W'($urandom));   // unmapped index, must be ignored
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin : watch_out
    denoise_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.row      = out_row;
      got.col      = out_col;
      got.pixel    = out_pixel;
      got.replaced = was_replaced;
      got.done     = frame_done;
      pixel_board.check_result(got);
      results_seen <= results_seen + 1;
    end
  end

  initial begin : result_sink
    int unsigned stall;
    bit          held_off;
    held_off = 1'b0;
    forever begin
      stall = draw_wait(recv_burst);
      // one long hold-off while input keeps coming: result queue fills, input must stall
      if (!held_off && results_seen >= HOLD_AFTER) begin
        stall    = HOLD_CYCLES;
        held_off = 1'b1;
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    logic [PIX_W-1:0] corner_frame [9];
    logic [PIX_W-1:0] base;
    logic [CFG_W-1:0] w, h, nw;
    int unsigned      random_items, sent, k, settled, cap;
    bit               tall_done;
    // interior pixel 0 among mostly 255: median of 254 and 255 truncates to 254
    corner_frame = '{8'd255, 8'd0, 8'd254, 8'd255, 8'd0, 8'd255, 8'd1, 8'd255, 8'd0};
    random_items = 0;
    tall_done    = 1'b0;

    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_geometry(CFG_W'(MIN_DIM), CFG_W'(MIN_DIM));
    for (int i = 0; i < 9; i++) send_pixel(corner_frame[i]);
    wait_idle();

    // flat 5x5 start, then cut the frame short at row 2 column 3: the column sits past
    // the new end and the row on the last row, so the next pixel closes the frame
    set_geometry(CFG_W'(5), CFG_W'(5));
    for (int i = 0; i < 13; i++) send_pixel(i == 7 ? 8'd0 : 8'd100);
    wait_idle();
    set_geometry(CFG_W'(MIN_DIM), CFG_W'(MIN_DIM));
    send_pixel(8'd255);
    wait_idle();

    // widest row, register values beyond range saturate; a narrow width then
    // turns the current column into the row end to keep the frame short
    base = PIX_W'($urandom_range(0, 255));
    set_geometry('1, '0);
    repeat (WIDE_LEAD) send_pixel(make_pixel(base));
    wait_idle();
    set_geometry(CFG_W'(MIN_DIM), '0);
    finish_frame(base, sent);
    wait_idle();

    while (random_items < RANDOM_ITEMS) begin
      if (!tall_done && random_items >= RANDOM_ITEMS / 2) begin
        // tallest frame, left early: the lower height makes the current row the last
        tall_done = 1'b1;
        base      = PIX_W'($urandom_range(0, 255));
        set_geometry(CFG_W'(1), '1);
        repeat (TALL_LEAD) send_pixel(make_pixel(base));
        wait_idle();
        set_geometry(CFG_W'(1), CFG_W'(MIN_DIM));
        finish_frame(base, sent);
        wait_idle();
      end
      w = ($urandom_range(0, 9) == 0) ? CFG_W'($urandom_range(13, 64))
                                       : CFG_W'($urandom_range(0, 12));
      h = (w > 12) ? CFG_W'($urandom_range(0, 4)) : CFG_W'($urandom_range(0, 9));
      base = PIX_W'($urandom_range(0, 255));
      set_geometry(w, h);
      if ($urandom_range(0, 3) == 0) begin
        // stop past row 0 so every column of the new width holds real line data
        k = $urandom_range(pixel_board.eff_width(),
                           pixel_board.eff_width() * pixel_board.eff_height() - 1);
        repeat (k) send_pixel(make_pixel(base));
        random_items += k;
        wait_idle();
        settled = pixel_board.settled_width();
        cap     = settled < MIDFRAME_MAXW ? settled : MIDFRAME_MAXW;
        nw      = (settled >= MIN_DIM) ? CFG_W'($urandom_range(0, cap))
                                       : pixel_board.width_reg;
        set_geometry(nw, CFG_W'($urandom_range(0, 12)));
      end
      finish_frame(base, sent);
      random_items += sent;
      wait_idle();
    end

    wait_idle();
    if (pixel_board.errors == 0 && pixel_board.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/nmd_pkg.sv
src/nmd_median.sv
src/neighbour_median_denoise.sv
src/nmd_checker.sv
tb/sv/tb_top.sv
